/* rtl/core/kmer_presence_bitmap_macros.svh */
// Assertion macros for the k-mer presence bitmap RTL.
`ifndef KMER_PRESENCE_BITMAP_MACROS_SVH
`define KMER_PRESENCE_BITMAP_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset.
`define KPB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kpb assertion failed");

// Next-cycle implication, checked on every clock outside reset.
`define KPB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kpb assertion failed");

`endif

/* rtl/core/kpb_pkg.sv */
// Shared types, constants and codes of the k-mer presence bitmap.
package kpb_pkg;

  localparam int KMER_W  = 20;
  localparam int COUNT_W = 32;
  localparam int BASE_W  = 3;
  localparam int FUNC_W  = 2;
  localparam int LEN_W   = 4;
  localparam int DIST_W  = 21;
  localparam int TOTAL_W = 40;

  localparam int K_MAX_DEFAULT = 10;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_KMER_LEN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT = 1'd1;

  localparam logic [LEN_W-1:0]   KMER_LEN_RESET  = 4'd10;
  localparam logic [COUNT_W-1:0] MIN_COUNT_RESET = 32'd256;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ROLL   = 2'd2;

  localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [KMER_W-1:0]  kmer;
    logic [COUNT_W-1:0] count;
    logic [BASE_W-1:0]  base;
  } kpb_in_t;

  typedef struct packed {
    logic               present;
    logic [KMER_W-1:0]  rolled_kmer;
    logic               bad_base;
    logic [DIST_W-1:0]  distinct_kmers;
    logic [TOTAL_W-1:0] at_total;
    logic [TOTAL_W-1:0] gc_total;
  } kpb_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_RD_FWD,
    ST_CHK_FWD,
    ST_RD_RC,
    ST_CHK_RC,
    ST_DONE
  } kpb_state_t;

  typedef struct packed {
    logic clr_step;
    logic cap_in;
    logic prep;
    logic rd_fwd;
    logic chk_fwd;
    logic rd_rc;
    logic chk_rc;
    logic load_out;
  } kpb_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic do_lookup;
    logic insert_hit;
    logic out_busy;
  } kpb_sts_t;

endpackage

/* rtl/core/kpb_ram.sv */
// Generic single-port RAM with registered read.
module kpb_ram #(
  parameter int WIDTH  = 1,
  parameter int ADDR_W = 20
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  localparam longint unsigned DEPTH = 64'd1 << ADDR_W;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* rtl/core/kpb_ctrl.sv */
// Controller state machine: sequences clearing, lookups and inserts.
module kpb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  kpb_pkg::kpb_sts_t sts,
  output kpb_pkg::kpb_cmd_t cmd
);

  kpb_pkg::kpb_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kpb_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      kpb_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = kpb_pkg::ST_IDLE;
        end
      end
      kpb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_next = kpb_pkg::ST_PREP;
        end
      end
      kpb_pkg::ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = sts.do_lookup ? kpb_pkg::ST_RD_FWD : kpb_pkg::ST_DONE;
      end
      kpb_pkg::ST_RD_FWD: begin
        cmd.rd_fwd = 1'b1;
        state_next = kpb_pkg::ST_CHK_FWD;
      end
      kpb_pkg::ST_CHK_FWD: begin
        cmd.chk_fwd = 1'b1;
        state_next  = sts.insert_hit ? kpb_pkg::ST_RD_RC : kpb_pkg::ST_DONE;
      end
      kpb_pkg::ST_RD_RC: begin
        cmd.rd_rc  = 1'b1;
        state_next = kpb_pkg::ST_CHK_RC;
      end
      kpb_pkg::ST_CHK_RC: begin
        cmd.chk_rc = 1'b1;
        state_next = kpb_pkg::ST_DONE;
      end
      kpb_pkg::ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = kpb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kpb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/kpb_dpath.sv */
// Datapath: config, rolling register, totals, bitmap RAM and output register.
`include "kmer_presence_bitmap_macros.svh"

module kpb_dpath #(
  parameter int K_MAX = kpb_pkg::K_MAX_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [kpb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kpb_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  kpb_pkg::kpb_in_t                  in_data,
  output kpb_pkg::kpb_out_t                 out_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  input  kpb_pkg::kpb_cmd_t                 cmd,
  output kpb_pkg::kpb_sts_t                 sts
);

  localparam int AW    = 2 * K_MAX;
  localparam int KW    = $clog2(K_MAX + 1);
  localparam int SUM_W = kpb_pkg::TOTAL_W + 1;

  // configuration
  logic [kpb_pkg::LEN_W-1:0]   kmer_len;
  logic [kpb_pkg::COUNT_W-1:0] min_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_len  <= kpb_pkg::KMER_LEN_RESET;
      min_count <= kpb_pkg::MIN_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kpb_pkg::CFG_KMER_LEN:  kmer_len  <= cfg_data[kpb_pkg::LEN_W-1:0];
        kpb_pkg::CFG_MIN_COUNT: min_count <= cfg_data[kpb_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective k, clamped to 1..K_MAX
  logic [4:0]    klen5;
  logic [KW-1:0] eff_k;

  always_comb begin
    klen5 = {1'b0, kmer_len};
    if (klen5 == 5'd0) begin
      eff_k = KW'(1);
    end else if (klen5 > 5'(K_MAX)) begin
      eff_k = KW'(K_MAX);
    end else begin
      eff_k = KW'(klen5);
    end
  end

  logic [kpb_pkg::KMER_W-1:0] mask_k;

  always_comb begin
    for (int i = 0; i < kpb_pkg::KMER_W; i++) begin
      mask_k[i] = (i < 2 * int'(eff_k));
    end
  end

  // captured item
  kpb_pkg::kpb_in_t in_q;

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      in_q <= in_data;
    end
  end

  logic is_insert, is_load, is_roll, bad_base, ge;

  assign is_insert = (in_q.func == kpb_pkg::FUNC_INSERT);
  assign is_load   = (in_q.func == kpb_pkg::FUNC_LOAD);
  assign is_roll   = (in_q.func == kpb_pkg::FUNC_ROLL);
  assign bad_base  = is_roll && in_q.base[2];
  assign ge        = (in_q.count >= min_count);

  // address and base-count preparation
  logic [kpb_pkg::KMER_W-1:0] rolling, rolled, roll_next;
  logic [AW-1:0]              fwd_ins, look_addr, rc_full, rc;
  logic [K_MAX-1:0]           at_vec;
  logic [KW-1:0]              at_cnt, rc_sh;

  always_comb begin
    fwd_ins = AW'(in_q.kmer & mask_k);
    rolled  = ({rolling[kpb_pkg::KMER_W-3:0], 2'b00} & mask_k)
            | {{(kpb_pkg::KMER_W-2){1'b0}}, in_q.base[1:0]};
    if (is_load) begin
      roll_next = in_q.kmer;
    end else if (is_roll && !in_q.base[2]) begin
      roll_next = rolled;
    end else begin
      roll_next = rolling;
    end
    look_addr = AW'(roll_next & mask_k);
    for (int j = 0; j < K_MAX; j++) begin
      rc_full[2*(K_MAX-1-j) +: 2] = ~fwd_ins[2*j +: 2];
      at_vec[j] = (fwd_ins[2*j] == fwd_ins[2*j+1]) && (j < int'(eff_k));
    end
    rc_sh  = KW'(K_MAX) - eff_k;
    rc     = rc_full >> {rc_sh, 1'b0};
    at_cnt = KW'($countones(at_vec));
  end

  logic [AW-1:0] addr_fwd, addr_rc;
  logic [KW-1:0] at_q, gc_q;
  logic          present;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      addr_fwd <= is_insert ? fwd_ins : look_addr;
      addr_rc  <= rc;
      at_q     <= at_cnt;
      gc_q     <= eff_k - at_cnt;
    end
  end

  // bitmap RAM; also swept to zero after reset
  logic [AW-1:0] clr_cnt, ram_addr;
  logic          ram_we, ram_re, ram_wbit;
  logic [0:0]    ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_comb begin
    priority if (cmd.clr_step) begin
      ram_addr = clr_cnt;
    end else if (cmd.rd_rc || cmd.chk_rc) begin
      ram_addr = addr_rc;
    end else begin
      ram_addr = addr_fwd;
    end
  end

  logic dist_inc;

  assign dist_inc = ((cmd.chk_fwd && is_insert && ge) || cmd.chk_rc) && !ram_rdata[0];
  assign ram_we   = cmd.clr_step || dist_inc;
  assign ram_re   = cmd.rd_fwd || cmd.rd_rc;
  assign ram_wbit = !cmd.clr_step;

  kpb_ram #(
    .WIDTH  (1),
    .ADDR_W (AW)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wbit),
    .rdata (ram_rdata)
  );

  // state registers and totals
  logic [kpb_pkg::DIST_W-1:0]  distinct;
  logic [kpb_pkg::TOTAL_W-1:0] at_sum, gc_sum;
  logic [SUM_W-1:0]            at_add, gc_add;

  assign at_add = {1'b0, at_sum} + SUM_W'(at_q);
  assign gc_add = {1'b0, gc_sum} + SUM_W'(gc_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      rolling  <= '0;
      distinct <= '0;
      at_sum   <= '0;
      gc_sum   <= '0;
    end else begin
      if (cmd.prep) begin
        rolling <= roll_next;
      end
      if (dist_inc && distinct != kpb_pkg::DIST_MAX) begin
        distinct <= distinct + 1'b1;
      end
      if (cmd.chk_fwd && is_insert && ge) begin
        at_sum <= at_add[SUM_W-1] ? kpb_pkg::TOTAL_MAX : at_add[kpb_pkg::TOTAL_W-1:0];
        gc_sum <= gc_add[SUM_W-1] ? kpb_pkg::TOTAL_MAX : gc_add[kpb_pkg::TOTAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      present <= 1'b0;
    end else if (cmd.chk_fwd) begin
      present <= ram_rdata[0];
    end
  end

  // output register
  kpb_pkg::kpb_out_t out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_q.present        <= present;
      out_q.rolled_kmer    <= rolling;
      out_q.bad_base       <= bad_base;
      out_q.distinct_kmers <= distinct;
      out_q.at_total       <= at_sum;
      out_q.gc_total       <= gc_sum;
    end
  end

  assign out_data = out_q;

  assign sts.clr_last   = &clr_cnt;
  assign sts.do_lookup  = is_insert || is_load || (is_roll && !in_q.base[2]);
  assign sts.insert_hit = is_insert && ge;
  assign sts.out_busy   = out_valid && !out_ready;

  `KPB_ASSERT_NOW(a_port_conflict, ram_we, !ram_re)
  `KPB_ASSERT_NOW(a_load_free, cmd.load_out, !(out_valid && !out_ready))
  `KPB_ASSERT_NEXT(a_dist_mono, 1'b1, distinct >= $past(distinct))
  `KPB_ASSERT_NEXT(a_dist_inc, dist_inc && distinct != kpb_pkg::DIST_MAX,
                   distinct == $past(distinct) + 1'b1)

endmodule

/* rtl/core/kmer_presence_bitmap.sv */
// Top level of the k-mer presence bitmap: controller, datapath and ports.
//
// Input channel in_valid/in_ready carries one kpb_in_t transaction (func, kmer,
// count, base); output channel out_valid/out_ready returns one kpb_out_t
// transaction per input. cfg_we/cfg_index/cfg_data write kmer_len (index 0) or
// min_count (index 1) in the same cycle; write them only while the block idles.
// One item is worked at a time on the single-port bitmap RAM with registered
// read. After acceptance, func 3 or a bad base passes PREP and DONE; a lookup
// or an insert below threshold passes PREP, RD_FWD, CHK_FWD and DONE; an
// insert at or above threshold adds RD_RC and CHK_RC (two read-modify-writes,
// forward and reverse complement). in_ready rises in the same cycle as
// out_valid, so a new item is taken only once the last result is loaded.
// Reset (synchronous, active high) restores the config defaults, zeroes the
// totals and the rolling register, then sweeps all 2**(2*K_MAX) bitmap bits
// (1,048,576 at K_MAX = 10) to zero one bit per cycle with in_ready low.
// A result waits in the output register while out_ready is low; the next item
// may be accepted and worked, and it holds in its last step until that
// register is free.
module kmer_presence_bitmap #(
  parameter int K_MAX = kpb_pkg::K_MAX_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [kpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kpb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  kpb_pkg::kpb_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output kpb_pkg::kpb_out_t              out_data
);

  kpb_pkg::kpb_cmd_t cmd;
  kpb_pkg::kpb_sts_t sts;

  kpb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kpb_dpath #(
    .K_MAX (K_MAX)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* sim/kmer_presence_bitmap_tb.sv */
// Self-checking testbench for kmer_presence_bitmap: directed table, then random phases.
module kmer_presence_bitmap_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [kpb_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int K_LIMIT = kpb_pkg::K_MAX_DEFAULT;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 80;
  localparam int TAIL_CYCLES = 16;
  // clearing sweep of all 2**20 bitmap bits after reset, plus a wide margin for traffic
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_TYPED} row_kind_t;

  typedef struct {
    row_kind_t                      kind;
    logic [kpb_pkg::CFG_DATA_W-1:0] len_word;
    logic [kpb_pkg::CFG_DATA_W-1:0] min_word;
    kpb_pkg::kpb_in_t               item;
    kpb_pkg::kpb_out_t              want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [kpb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [kpb_pkg::CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  kpb_pkg::kpb_in_t in_data;
  logic out_valid;
  logic out_ready;
  kpb_pkg::kpb_out_t out_data;

  // shadow copy of the block's state
  bit shadow_map [0:(1 << kpb_pkg::KMER_W) - 1];
  logic [kpb_pkg::KMER_W-1:0]  shadow_roll = '0;
  logic [kpb_pkg::DIST_W-1:0]  shadow_distinct = '0;
  logic [kpb_pkg::TOTAL_W-1:0] shadow_at = '0;
  logic [kpb_pkg::TOTAL_W-1:0] shadow_gc = '0;
  logic [kpb_pkg::LEN_W-1:0]   len_reg = kpb_pkg::KMER_LEN_RESET;
  logic [kpb_pkg::COUNT_W-1:0] min_reg = kpb_pkg::MIN_COUNT_RESET;

  kpb_pkg::kpb_out_t awaited_results[$];
  logic [kpb_pkg::KMER_W-1:0] planted_kmers[$];
  plan_row_t plan[$];

  bit calm = 1'b0;
  int unsigned cycles = 0;
  int mismatches = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int inserts_sent = 0;
  int rolls_sent = 0;
  int bad_bases_sent = 0;
  int settings_used = 0;

  kmer_presence_bitmap uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #6 clk = ~clk;

  function automatic void set_bit(logic [kpb_pkg::KMER_W-1:0] addr);
    if (!shadow_map[addr]) begin
      shadow_map[addr] = 1'b1;
      if (shadow_distinct != kpb_pkg::DIST_MAX) shadow_distinct = shadow_distinct + 1'b1;
    end
  endfunction

  // Advances the shadow state by one transaction and returns the result it yields.
  function automatic kpb_pkg::kpb_out_t bitmap_step(kpb_pkg::kpb_in_t it);
    kpb_pkg::kpb_out_t r;
    int unsigned k;
    int unsigned at_n;
    int unsigned i;
    logic [63:0] wide_mask;
    logic [kpb_pkg::KMER_W-1:0] msk, fwd, rc, walk;
    logic [kpb_pkg::TOTAL_W:0] sum;
    k = (len_reg == 0) ? 1 : (len_reg > K_LIMIT) ? K_LIMIT : len_reg;
    wide_mask = (64'd1 << (2 * k)) - 64'd1;
    msk = wide_mask[kpb_pkg::KMER_W-1:0];
    r = '0;
    case (it.func)
      kpb_pkg::FUNC_INSERT: begin
        fwd = it.kmer & msk;
        r.present = shadow_map[fwd];
        if (it.count >= min_reg) begin
          rc = '0;
          walk = fwd;
          at_n = 0;
          for (i = 0; i < k; i++) begin
            rc = {rc[kpb_pkg::KMER_W-3:0], 2'd3 - walk[1:0]};
            if (walk[1:0] == 2'd0 || walk[1:0] == 2'd3) at_n++;
            walk = walk >> 2;
          end
          // a palindrome hits the same bit twice and counts once
          set_bit(fwd);
          set_bit(rc);
          sum = shadow_at;
          sum = sum + at_n;
          shadow_at = sum[kpb_pkg::TOTAL_W] ? kpb_pkg::TOTAL_MAX : sum[kpb_pkg::TOTAL_W-1:0];
          sum = shadow_gc;
          sum = sum + (k - at_n);
          shadow_gc = sum[kpb_pkg::TOTAL_W] ? kpb_pkg::TOTAL_MAX : sum[kpb_pkg::TOTAL_W-1:0];
        end
      end
      kpb_pkg::FUNC_LOAD: begin
        shadow_roll = it.kmer;
        r.present = shadow_map[shadow_roll & msk];
      end
      kpb_pkg::FUNC_ROLL: begin
        if (it.base >= 3'd4) begin
          r.bad_base = 1'b1;
        end else begin
          shadow_roll = ((shadow_roll << 2) & msk) | it.base[1:0];
          r.present = shadow_map[shadow_roll & msk];
        end
      end
      default: ;
    endcase
    r.rolled_kmer = shadow_roll;
    r.distinct_kmers = shadow_distinct;
    r.at_total = shadow_at;
    r.gc_total = shadow_gc;
    return r;
  endfunction

  function automatic void check_result(kpb_pkg::kpb_out_t want, kpb_pkg::kpb_out_t got);
    if (got.present !== want.present) begin
      $display("%0t: present expected %0h, got %0h", $time, want.present, got.present);
      mismatches++;
    end
    if (got.rolled_kmer !== want.rolled_kmer) begin
      $display("%0t: rolled_kmer expected %0h, got %0h", $time, want.rolled_kmer,
               got.rolled_kmer);
      mismatches++;
    end
    if (got.bad_base !== want.bad_base) begin
      $display("%0t: bad_base expected %0h, got %0h", $time, want.bad_base, got.bad_base);
      mismatches++;
    end
    if (got.distinct_kmers !== want.distinct_kmers) begin
      $display("%0t: distinct_kmers expected %0h, got %0h", $time, want.distinct_kmers,
               got.distinct_kmers);
      mismatches++;
    end
    if (got.at_total !== want.at_total) begin
      $display("%0t: at_total expected %0h, got %0h", $time, want.at_total, got.at_total);
      mismatches++;
    end
    if (got.gc_total !== want.gc_total) begin
      $display("%0t: gc_total expected %0h, got %0h", $time, want.gc_total, got.gc_total);
      mismatches++;
    end
  endfunction

  function automatic plan_row_t cfg_row(logic [kpb_pkg::CFG_DATA_W-1:0] len_word,
                                        logic [kpb_pkg::CFG_DATA_W-1:0] min_word);
    plan_row_t row;
    row = '{kind: ROW_CFG, len_word: len_word, min_word: min_word, item: '0, want: '0};
    return row;
  endfunction

  function automatic plan_row_t item_row(logic [kpb_pkg::FUNC_W-1:0] func,
                                         logic [kpb_pkg::KMER_W-1:0] kmer,
                                         logic [kpb_pkg::COUNT_W-1:0] count,
                                         logic [kpb_pkg::BASE_W-1:0] base);
    plan_row_t row;
    row = '{kind: ROW_ITEM, len_word: '0, min_word: '0, item: '0, want: '0};
    row.item = '{func: func, kmer: kmer, count: count, base: base};
    return row;
  endfunction

  function automatic plan_row_t typed_row(logic [kpb_pkg::FUNC_W-1:0] func,
                                          logic [kpb_pkg::KMER_W-1:0] kmer,
                                          logic [kpb_pkg::COUNT_W-1:0] count,
                                          logic [kpb_pkg::BASE_W-1:0] base,
                                          logic present, logic [kpb_pkg::KMER_W-1:0] rolled,
                                          logic bad, logic [kpb_pkg::DIST_W-1:0] dist_n,
                                          logic [kpb_pkg::TOTAL_W-1:0] at,
                                          logic [kpb_pkg::TOTAL_W-1:0] gc);
    plan_row_t row;
    row = item_row(func, kmer, count, base);
    row.kind = ROW_TYPED;
    row.want = '{present: present, rolled_kmer: rolled, bad_base: bad,
                 distinct_kmers: dist_n, at_total: at, gc_total: gc};
    return row;
  endfunction

  // Random transaction; part of the kmers come from earlier inserts or extend
  // the rolling register so that lookups hit.
  function automatic kpb_pkg::kpb_in_t draw_item();
    kpb_pkg::kpb_in_t it;
    int unsigned pick;
    longint near;
    pick = $urandom_range(0, 19);
    it.func = (pick < 8) ? kpb_pkg::FUNC_INSERT : (pick < 11) ? kpb_pkg::FUNC_LOAD :
              (pick < 19) ? kpb_pkg::FUNC_ROLL : FUNC_UNUSED;
    pick = $urandom_range(0, 3);
    if (pick == 2 && planted_kmers.size() != 0)
      it.kmer = planted_kmers[$urandom_range(0, planted_kmers.size() - 1)];
    else if (pick == 3)
      it.kmer = {shadow_roll[kpb_pkg::KMER_W-3:0], 2'($urandom_range(0, 3))};
    else
      it.kmer = kpb_pkg::KMER_W'($urandom());
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      near = longint'(min_reg) + longint'($urandom_range(0, 4)) - 2;
      if (near < 0) near = 0;
      if (near > 64'hFFFF_FFFF) near = 64'hFFFF_FFFF;
      it.count = near[kpb_pkg::COUNT_W-1:0];
    end else if (pick < 8) begin
      it.count = $urandom();
    end else begin
      it.count = (pick == 8) ? '0 : '1;
    end
    it.base = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 3)) : 3'($urandom_range(4, 7));
    if (it.func == kpb_pkg::FUNC_INSERT) begin
      planted_kmers.push_back(it.kmer);
      if (planted_kmers.size() > 64) void'(planted_kmers.pop_front());
    end
    return it;
  endfunction

  // Leaves in_valid high after acceptance; the caller lowers it or sends again.
  task automatic send_item(input kpb_pkg::kpb_in_t it, input bit typed,
                           input kpb_pkg::kpb_out_t want);
    kpb_pkg::kpb_out_t predicted;
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = bitmap_step(it);
    awaited_results.push_back(typed ? want : predicted);
    if (it.func == kpb_pkg::FUNC_INSERT) inserts_sent++;
    if (it.func == kpb_pkg::FUNC_ROLL) rolls_sent++;
    if (it.func == kpb_pkg::FUNC_ROLL && it.base >= 3'd4) bad_bases_sent++;
  endtask

  task automatic pause_input(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Both registers, written back to back once the block has drained.
  task automatic write_config(input logic [kpb_pkg::CFG_DATA_W-1:0] len_word,
                              input logic [kpb_pkg::CFG_DATA_W-1:0] min_word);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= kpb_pkg::CFG_KMER_LEN;
    cfg_data <= len_word;
    @(posedge clk);
    cfg_index <= kpb_pkg::CFG_MIN_COUNT;
    cfg_data <= min_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    len_reg = len_word[kpb_pkg::LEN_W-1:0];
    min_reg = min_word;
    settings_used++;
  endtask

  // Output side: ready runs broken by stall bursts, none in the final phase.
  always begin : drain
    out_ready <= 1'b1;
    repeat ($urandom_range(1, 30)) @(posedge clk);
    if (!calm && $urandom_range(0, 2) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, got %h", $time, out_data);
        mismatches++;
      end else begin
        check_result(awaited_results.pop_front(), out_data);
      end
      results_seen++;
      if (out_data.present) hits_seen++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d transactions outstanding", cycles,
               awaited_results.size());
      $display("kmer_presence_bitmap_tb failed");
      $finish;
    end
  end

  initial begin : stimulus
    int p;
    int j;
    logic [kpb_pkg::CFG_DATA_W-1:0] len_word;
    logic [kpb_pkg::CFG_DATA_W-1:0] min_word;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= kpb_pkg::CFG_KMER_LEN;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_data <= '0;

    // defaults after reset: k = 10, threshold 256
    plan.push_back(typed_row(kpb_pkg::FUNC_LOAD, 20'h00000, 32'h0, 3'd0,
                             0, 20'h00000, 0, 0, 0, 0));
    plan.push_back(typed_row(kpb_pkg::FUNC_LOAD, 20'hFFFFF, 32'h0, 3'd0,
                             0, 20'hFFFFF, 0, 0, 0, 0));
    plan.push_back(typed_row(kpb_pkg::FUNC_ROLL, 20'h0, 32'h0, 3'd7,
                             0, 20'hFFFFF, 1, 0, 0, 0));
    plan.push_back(typed_row(kpb_pkg::FUNC_ROLL, 20'h0, 32'h0, 3'd4,
                             0, 20'hFFFFF, 1, 0, 0, 0));
    plan.push_back(typed_row(FUNC_UNUSED, 20'h12345, '1, 3'd7,
                             0, 20'hFFFFF, 0, 0, 0, 0));
    // threshold edge on all-A: below, at, far above
    plan.push_back(typed_row(kpb_pkg::FUNC_INSERT, 20'h0, 32'd255, 3'd0,
                             0, 20'hFFFFF, 0, 0, 0, 0));
    plan.push_back(typed_row(kpb_pkg::FUNC_INSERT, 20'h0, 32'd256, 3'd0,
                             0, 20'hFFFFF, 0, 2, 10, 0));
    plan.push_back(typed_row(kpb_pkg::FUNC_INSERT, 20'h0, '1, 3'd0,
                             1, 20'hFFFFF, 0, 2, 20, 0));
    plan.push_back(typed_row(kpb_pkg::FUNC_ROLL, 20'h0, 32'h0, 3'd3,
                             1, 20'hFFFFF, 0, 2, 20, 0));
    // AAAAATTTTT is its own reverse complement
    plan.push_back(typed_row(kpb_pkg::FUNC_INSERT, 20'h003FF, 32'd256, 3'd0,
                             0, 20'hFFFFF, 0, 3, 30, 0));
    plan.push_back(typed_row(kpb_pkg::FUNC_LOAD, 20'h003FF, 32'h0, 3'd0,
                             1, 20'h003FF, 0, 3, 30, 0));
    plan.push_back(item_row(kpb_pkg::FUNC_ROLL, 20'h0, 32'h0, 3'd0));
    plan.push_back(item_row(kpb_pkg::FUNC_INSERT, 20'h556AA, 32'd300, 3'd0));
    plan.push_back(item_row(kpb_pkg::FUNC_INSERT, 20'h12345, 32'd256, 3'd1));
    plan.push_back(cfg_row(32'd1, 32'd0));
    plan.push_back(item_row(kpb_pkg::FUNC_INSERT, 20'hFFFFE, 32'd0, 3'd0));
    plan.push_back(item_row(kpb_pkg::FUNC_ROLL, 20'h0, 32'h0, 3'd1));
    plan.push_back(item_row(kpb_pkg::FUNC_INSERT, 20'h0, 32'd0, 3'd0));
    // length 0 behaves as 1
    plan.push_back(cfg_row(32'd0, '1));
    plan.push_back(item_row(kpb_pkg::FUNC_INSERT, 20'h3, 32'hFFFF_FFFE, 3'd0));
    plan.push_back(item_row(kpb_pkg::FUNC_INSERT, 20'h3, '1, 3'd0));
    plan.push_back(item_row(kpb_pkg::FUNC_ROLL, 20'h0, 32'h0, 3'd2));
    // upper data bits ignored; stale register bits outside the mask
    plan.push_back(cfg_row(32'hFFFF_FFF3, 32'd256));
    plan.push_back(item_row(kpb_pkg::FUNC_LOAD, 20'hABCDE, 32'h0, 3'd0));
    plan.push_back(item_row(kpb_pkg::FUNC_ROLL, 20'h0, 32'h0, 3'd2));
    plan.push_back(item_row(kpb_pkg::FUNC_ROLL, 20'h0, 32'h0, 3'd5));
    // length above the maximum behaves as the maximum
    plan.push_back(cfg_row(32'd15, 32'd256));
    plan.push_back(item_row(kpb_pkg::FUNC_LOAD, 20'hFFFFF, 32'h0, 3'd0));
    plan.push_back(item_row(kpb_pkg::FUNC_ROLL, 20'h0, 32'h0, 3'd0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    settings_used = 1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG)
        write_config(plan[i].len_word, plan[i].min_word);
      else
        send_item(plan[i].item, plan[i].kind == ROW_TYPED, plan[i].want);
    end

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin len_word = 32'd10; min_word = 32'd256; end
        1: begin len_word = 32'd1; min_word = 32'd0; end
        2: begin len_word = 32'd2; min_word = $urandom_range(0, 1024); end
        3: begin len_word = 32'd0; min_word = '1; end
        4: begin len_word = 32'd4; min_word = 32'd256; end
        5: begin len_word = 32'd15; min_word = $urandom(); end
        6: begin len_word = $urandom(); min_word = 32'd128; end
        default: begin len_word = 32'd3; min_word = 32'd256; end
      endcase
      write_config(len_word, min_word);
      calm = (p == PHASES - 1);
      for (j = 0; j < PHASE_ITEMS; j++) begin
        if (!calm && $urandom_range(0, 3) == 0) pause_input($urandom_range(1, 15));
        send_item(draw_item(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d transactions checked under %0d register settings, %0d lookups hit",
             results_seen, settings_used, hits_seen);
    $display("%0d inserts, %0d rolls of which %0d with an invalid base, %0d mismatches",
             inserts_sent, rolls_sent, bad_bases_sent, mismatches);
    if (mismatches == 0)
      $display("kmer_presence_bitmap_tb passed");
    else
      $display("kmer_presence_bitmap_tb failed");
    $finish;
  end

endmodule
